// File: design/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Blob feature accumulator package
// Shared types and constants: request codes, register indexes, field widths,
// the layout of one per-label feature entry and the divider states.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // Field widths of the request and result channels.
    localparam int unsigned C_FUNC_W  = 2;
    localparam int unsigned C_LABEL_W = 8;
    localparam int unsigned C_POS_W   = 12;
    localparam int unsigned C_SIDE_W  = 13;
    localparam int unsigned C_CNT_W   = 25;
    localparam int unsigned C_SUM_W   = 36;

    // Dividend width of the rounded mean: 2 * sum + count.
    localparam int unsigned C_DIV_W   = C_SUM_W + 2;

    // Configuration port.
    localparam int unsigned C_CFG_IDX_W  = 1;
    localparam int unsigned C_CFG_DATA_W = C_SIDE_W;

    // Largest image side; register values above it act as this value.
    localparam logic [C_SIDE_W-1:0] C_MAX_SIDE      = 13'd4096;
    localparam logic [C_SIDE_W-1:0] C_WIDTH_RESET   = 13'd640;
    localparam logic [C_SIDE_W-1:0] C_HEIGHT_RESET  = 13'd480;

    // Request codes carried in the func field.
    typedef enum logic [C_FUNC_W-1:0] {
        FUNC_PIXEL = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    // Configuration register indexes.
    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    // One label's accumulated features as stored in the entry memory.
    typedef struct packed {
        logic [C_CNT_W-1:0] count;
        logic [C_SUM_W-1:0] sum_x;
        logic [C_SUM_W-1:0] sum_y;
        logic [C_POS_W-1:0] min_x;
        logic [C_POS_W-1:0] max_x;
        logic [C_POS_W-1:0] min_y;
        logic [C_POS_W-1:0] max_y;
    } t_entry;

    // Centroid divider sequencer.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

endpackage

// File: design/blob_feature_accumulator.sv
// Pixel requests: one accepted per cycle unless a read stalls the input; a read-modify-write
// of the entry memory, read at acceptance and written in stage one. Read requests: the
// result is set by the 12-step restoring divider that forms both centroids, one quotient
// bit per cycle; the input stalls until the result register loads, later under output stall.
// Reset is synchronous: valid bits, position and handshakes clear at once and the size
// registers take their reset values; the entry memory has no clearing pass.
// ----------------------------------------------------------------------------
// Blob feature accumulator
// Tracks the raster position of a stream of label pixels and accumulates area,
// coordinate sums and bounding box per label in a synchronous entry memory.
// A read request returns area, rounded centroid and bounding box of one label.
// ----------------------------------------------------------------------------
module blob_feature_accumulator
    import bfa_pkg::*;
#(
    parameter int unsigned LABEL_COUNT = 256
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write port.
    input  logic                    i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [C_CFG_DATA_W-1:0] i_cfg_wdata,
    // Request channel.
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [C_FUNC_W-1:0]     i_func,
    input  logic [C_LABEL_W-1:0]    i_label,
    // Result channel.
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_present,
    output logic [C_CNT_W-1:0]      o_area,
    output logic [C_POS_W-1:0]      o_centroid_x,
    output logic [C_POS_W-1:0]      o_centroid_y,
    output logic [C_POS_W-1:0]      o_box_left,
    output logic [C_POS_W-1:0]      o_box_top,
    output logic [C_SIDE_W-1:0]     o_box_width,
    output logic [C_SIDE_W-1:0]     o_box_height
);

    localparam int unsigned LW     = $clog2(LABEL_COUNT);
    localparam int unsigned QW     = C_POS_W;
    localparam int unsigned STEP_W = $clog2(QW);

    // ------------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------------
    logic [C_SIDE_W-1:0]    r_cfg_width;
    logic [C_SIDE_W-1:0]    r_cfg_height;
    logic [C_SIDE_W-1:0]    w_side_w;
    logic [C_SIDE_W-1:0]    w_side_h;

    logic [C_POS_W-1:0]     r_pos_x;
    logic [C_POS_W-1:0]     r_pos_y;
    logic [C_POS_W-1:0]     n_pos_x;
    logic [C_POS_W-1:0]     n_pos_y;

    logic                   w_accept;
    logic                   w_in_label_ok;
    logic [LW-1:0]          w_in_idx;

    logic                   r_s1_valid;
    logic [C_FUNC_W-1:0]    r_s1_func;
    logic                   r_s1_label_ok;
    logic [LW-1:0]          r_s1_idx;
    logic [C_POS_W-1:0]     r_s1_x;
    logic [C_POS_W-1:0]     r_s1_y;

    t_entry                 r_mem [LABEL_COUNT];
    t_entry                 r_mem_q;
    logic [LABEL_COUNT-1:0] r_entry_valid;

    logic                   r_fwd_hit;
    t_entry                 r_fwd_entry;

    t_entry                 w_cur;
    logic                   w_cur_valid;
    logic                   w_wr_en;
    t_entry                 w_wr_entry;
    logic                   w_s1_read;
    logic                   w_s1_clear;

    t_div_state             r_state;
    t_div_state             n_state;
    logic                   w_div_load;
    logic                   w_div_step;
    logic                   w_out_load;

    logic [STEP_W-1:0]      r_step_cnt;
    logic [C_DIV_W-1:0]     r_rem_x;
    logic [C_DIV_W-1:0]     r_rem_y;
    logic [C_DIV_W-1:0]     r_dsh;
    logic [QW-1:0]          r_q_x;
    logic [QW-1:0]          r_q_y;
    logic                   w_ge_x;
    logic                   w_ge_y;

    logic                   r_rd_present;
    logic [C_CNT_W-1:0]     r_rd_area;
    logic [C_POS_W-1:0]     r_rd_left;
    logic [C_POS_W-1:0]     r_rd_top;
    logic [C_SIDE_W-1:0]    r_rd_bw;
    logic [C_SIDE_W-1:0]    r_rd_bh;

    logic                   r_out_valid;
    logic                   r_out_present;
    logic [C_CNT_W-1:0]     r_out_area;
    logic [C_POS_W-1:0]     r_out_cx;
    logic [C_POS_W-1:0]     r_out_cy;
    logic [C_POS_W-1:0]     r_out_left;
    logic [C_POS_W-1:0]     r_out_top;
    logic [C_SIDE_W-1:0]    r_out_bw;
    logic [C_SIDE_W-1:0]    r_out_bh;

    // ------------------------------------------------------------------------
    // Configuration registers and effective image size
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= C_WIDTH_RESET;
            r_cfg_height <= C_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:  r_cfg_width  <= i_cfg_wdata;
                CFG_HEIGHT: r_cfg_height <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // A size of zero acts as one, a size above the maximum as the maximum.
    always_comb begin
        if (r_cfg_width == '0) begin
            w_side_w = C_SIDE_W'(1);
        end else if (r_cfg_width > C_MAX_SIDE) begin
            w_side_w = C_MAX_SIDE;
        end else begin
            w_side_w = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            w_side_h = C_SIDE_W'(1);
        end else if (r_cfg_height > C_MAX_SIDE) begin
            w_side_h = C_MAX_SIDE;
        end else begin
            w_side_h = r_cfg_height;
        end
    end

    // ------------------------------------------------------------------------
    // Request acceptance
    // ------------------------------------------------------------------------
    // A read request holds the input until its result has been formed.
    assign w_s1_read  = r_s1_valid && (r_s1_func == FUNC_READ);
    assign w_s1_clear = r_s1_valid && (r_s1_func == FUNC_CLEAR);
    assign o_stall    = (r_state != DIV_IDLE) || w_s1_read;
    assign w_accept   = i_valid && !o_stall;

    assign w_in_label_ok = (i_label != '0) &&
                           ({1'b0, i_label} < (C_LABEL_W + 1)'(LABEL_COUNT));
    assign w_in_idx      = i_label[LW-1:0];

    // ------------------------------------------------------------------------
    // Raster position: advances on every pixel, returns to the origin on clear
    // ------------------------------------------------------------------------
    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        if (w_accept && (i_func == FUNC_CLEAR)) begin
            n_pos_x = '0;
            n_pos_y = '0;
        end else if (w_accept && (i_func == FUNC_PIXEL)) begin
            if (({1'b0, r_pos_x} + C_SIDE_W'(1)) >= w_side_w) begin
                n_pos_x = '0;
                if (({1'b0, r_pos_y} + C_SIDE_W'(1)) >= w_side_h) begin
                    n_pos_y = '0;
                end else begin
                    n_pos_y = r_pos_y + C_POS_W'(1);
                end
            end else begin
                n_pos_x = r_pos_x + C_POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
        end
    end

    // ------------------------------------------------------------------------
    // Stage one: the request whose entry is being read from memory
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            // The entry written this cycle is newer than what memory returns.
            r_fwd_hit  <= w_accept && w_wr_en && (r_s1_idx == w_in_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_func     <= i_func;
            r_s1_label_ok <= w_in_label_ok;
            r_s1_idx      <= w_in_idx;
            r_s1_x        <= r_pos_x;
            r_s1_y        <= r_pos_y;
        end
        if (w_wr_en) begin
            r_fwd_entry <= w_wr_entry;
        end
    end

    // ------------------------------------------------------------------------
    // Entry memory: one read port at acceptance, one write port in stage one
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_s1_idx] <= w_wr_entry;
        end
        if (w_accept) begin
            r_mem_q <= r_mem[w_in_idx];
        end
    end

    // Valid bits: set on a label's first pixel, all dropped by a clear request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (w_s1_clear) begin
            r_entry_valid <= '0;
        end else if (w_wr_en) begin
            r_entry_valid[r_s1_idx] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Entry update for a pixel request
    // ------------------------------------------------------------------------
    assign w_cur       = r_fwd_hit ? r_fwd_entry : r_mem_q;
    assign w_cur_valid = r_entry_valid[r_s1_idx];

    // A full count freezes the entry.
    assign w_wr_en = r_s1_valid && (r_s1_func == FUNC_PIXEL) && r_s1_label_ok &&
                     (!w_cur_valid || !w_cur.count[C_CNT_W-1]);

    always_comb begin
        if (!w_cur_valid) begin
            w_wr_entry.count = C_CNT_W'(1);
            w_wr_entry.sum_x = C_SUM_W'(r_s1_x);
            w_wr_entry.sum_y = C_SUM_W'(r_s1_y);
            w_wr_entry.min_x = r_s1_x;
            w_wr_entry.max_x = r_s1_x;
            w_wr_entry.min_y = r_s1_y;
            w_wr_entry.max_y = r_s1_y;
        end else begin
            w_wr_entry.count = w_cur.count + C_CNT_W'(1);
            w_wr_entry.sum_x = w_cur.sum_x + C_SUM_W'(r_s1_x);
            w_wr_entry.sum_y = w_cur.sum_y + C_SUM_W'(r_s1_y);
            w_wr_entry.min_x = (r_s1_x < w_cur.min_x) ? r_s1_x : w_cur.min_x;
            w_wr_entry.max_x = (r_s1_x > w_cur.max_x) ? r_s1_x : w_cur.max_x;
            w_wr_entry.min_y = (r_s1_y < w_cur.min_y) ? r_s1_y : w_cur.min_y;
            w_wr_entry.max_y = (r_s1_y > w_cur.max_y) ? r_s1_y : w_cur.max_y;
        end
    end

    // ------------------------------------------------------------------------
    // Divider sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: begin
                if (w_s1_read) begin
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                if (r_step_cnt == '0) begin
                    n_state = DIV_DONE;
                end
            end
            DIV_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = DIV_IDLE;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
    end

    // Divider sequencer: outputs.
    always_comb begin
        w_div_load = 1'b0;
        w_div_step = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            DIV_IDLE: w_div_load = w_s1_read;
            DIV_RUN:  w_div_step = 1'b1;
            DIV_DONE: w_out_load = !r_out_valid || !i_stall;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // Centroid divider: floor((2 * sum + count) / (2 * count)), one bit a cycle
    // ------------------------------------------------------------------------
    assign w_ge_x = (r_rem_x >= r_dsh);
    assign w_ge_y = (r_rem_y >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (w_div_load) begin
            r_step_cnt   <= STEP_W'(QW - 1);
            r_rem_x      <= C_DIV_W'({w_cur.sum_x, 1'b0}) + C_DIV_W'(w_cur.count);
            r_rem_y      <= C_DIV_W'({w_cur.sum_y, 1'b0}) + C_DIV_W'(w_cur.count);
            r_dsh        <= C_DIV_W'({w_cur.count, 1'b0}) << (QW - 1);
            r_q_x        <= '0;
            r_q_y        <= '0;
            r_rd_present <= r_s1_label_ok && w_cur_valid;
            // An absent label reads as all zeros.
            if (r_s1_label_ok && w_cur_valid) begin
                r_rd_area <= w_cur.count;
                r_rd_left <= w_cur.min_x;
                r_rd_top  <= w_cur.min_y;
                r_rd_bw   <= {1'b0, w_cur.max_x} - {1'b0, w_cur.min_x} + C_SIDE_W'(1);
                r_rd_bh   <= {1'b0, w_cur.max_y} - {1'b0, w_cur.min_y} + C_SIDE_W'(1);
            end else begin
                r_rd_area <= '0;
                r_rd_left <= '0;
                r_rd_top  <= '0;
                r_rd_bw   <= '0;
                r_rd_bh   <= '0;
            end
        end else if (w_div_step) begin
            r_step_cnt <= r_step_cnt - STEP_W'(1);
            r_dsh      <= r_dsh >> 1;
            r_q_x      <= {r_q_x[QW-2:0], w_ge_x};
            r_q_y      <= {r_q_y[QW-2:0], w_ge_y};
            if (w_ge_x) begin
                r_rem_x <= r_rem_x - r_dsh;
            end
            if (w_ge_y) begin
                r_rem_y <= r_rem_y - r_dsh;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_present <= r_rd_present;
            r_out_area    <= r_rd_area;
            r_out_cx      <= r_rd_present ? r_q_x : '0;
            r_out_cy      <= r_rd_present ? r_q_y : '0;
            r_out_left    <= r_rd_left;
            r_out_top     <= r_rd_top;
            r_out_bw      <= r_rd_bw;
            r_out_bh      <= r_rd_bh;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_present    = r_out_present;
    assign o_area       = r_out_area;
    assign o_centroid_x = r_out_cx;
    assign o_centroid_y = r_out_cy;
    assign o_box_left   = r_out_left;
    assign o_box_top    = r_out_top;
    assign o_box_width  = r_out_bw;
    assign o_box_height = r_out_bh;

endmodule

// File: bench/blob_feature_accumulator_tb.sv
// ----------------------------------------------------------------------------
// Blob feature accumulator testbench
// Streams label pixels, read and clear requests into the accumulator and
// checks every read result against a cycle-free prediction of area, rounded
// centroid and bounding box. Both channels idle and stall at random, and the
// image size is reprogrammed between phases, extremes and mid-frame included.
// ----------------------------------------------------------------------------
module blob_feature_accumulator_tb
    import bfa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LABELS       = 256;
    localparam int unsigned COUNT_LIMIT  = 16777216;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned PRINT_LIMIT  = 100;

    // Code with no operation behind it; the block must ignore it.
    localparam logic [C_FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // One read result as it leaves the block.
    typedef struct packed {
        logic                present;
        logic [C_CNT_W-1:0]  area;
        logic [C_POS_W-1:0]  centroid_x;
        logic [C_POS_W-1:0]  centroid_y;
        logic [C_POS_W-1:0]  box_left;
        logic [C_POS_W-1:0]  box_top;
        logic [C_SIDE_W-1:0] box_width;
        logic [C_SIDE_W-1:0] box_height;
    } t_blob_features;

    // Tracks raster position and per-label features, and queues the features
    // that each read request should return.
    class blob_feature_scoreboard;
        int unsigned          err_count;
        logic [C_SIDE_W-1:0]  row_len_reg;
        logic [C_SIDE_W-1:0]  frame_rows_reg;
        bit                   label_seen[LABELS];
        int unsigned          area_acc[LABELS];
        longint unsigned      x_total[LABELS];
        longint unsigned      y_total[LABELS];
        int unsigned          x_lo[LABELS];
        int unsigned          x_hi[LABELS];
        int unsigned          y_lo[LABELS];
        int unsigned          y_hi[LABELS];
        int unsigned          col;
        int unsigned          row;
        t_blob_features       expected_features[$];

        function new();
            err_count      = 0;
            row_len_reg    = C_WIDTH_RESET;
            frame_rows_reg = C_HEIGHT_RESET;
            foreach (label_seen[i]) begin
                label_seen[i] = 1'b0;
                area_acc[i]   = 0;
                x_total[i]    = 0;
                y_total[i]    = 0;
                x_lo[i]       = 0;
                x_hi[i]       = 0;
                y_lo[i]       = 0;
                y_hi[i]       = 0;
            end
            col = 0;
            row = 0;
        endfunction

        function void apply_register(t_cfg_idx idx, logic [C_CFG_DATA_W-1:0] data);
            if (idx == CFG_WIDTH)
                row_len_reg = data;
            else
                frame_rows_reg = data;
        endfunction

        // Zero acts as one, anything past the largest side as the largest side.
        function int unsigned clamp_side(logic [C_SIDE_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > C_MAX_SIDE)
                return 32'(C_MAX_SIDE);
            return 32'(v);
        endfunction

        // Mean rounded to nearest with halves going up.
        function logic [C_POS_W-1:0] rounded_mean(longint unsigned total, int unsigned n);
            longint unsigned c;
            c = 64'(n);
            return C_POS_W'((2 * total + c) / (2 * c));
        endfunction

        function int unsigned pending();
            return expected_features.size();
        endfunction

        // Apply one accepted request to the prediction.
        function void note_request(logic [C_FUNC_W-1:0] func, logic [C_LABEL_W-1:0] label);
            int unsigned    lab;
            int unsigned    w;
            int unsigned    h;
            t_blob_features want;
            lab = 32'(label);
            case (func)
                FUNC_PIXEL: begin
                    // A first pixel opens the entry; a full count freezes it.
                    if (lab != 0 && lab < LABELS) begin
                        if (!label_seen[lab]) begin
                            label_seen[lab] = 1'b1;
                            area_acc[lab]   = 1;
                            x_total[lab]    = 64'(col);
                            y_total[lab]    = 64'(row);
                            x_lo[lab]       = col;
                            x_hi[lab]       = col;
                            y_lo[lab]       = row;
                            y_hi[lab]       = row;
                        end else if (area_acc[lab] < COUNT_LIMIT) begin
                            area_acc[lab]++;
                            x_total[lab] += 64'(col);
                            y_total[lab] += 64'(row);
                            if (col < x_lo[lab]) x_lo[lab] = col;
                            if (col > x_hi[lab]) x_hi[lab] = col;
                            if (row < y_lo[lab]) y_lo[lab] = row;
                            if (row > y_hi[lab]) y_hi[lab] = row;
                        end
                    end
                    // Step along the row; a position past a shrunken size wraps too.
                    w = clamp_side(row_len_reg);
                    h = clamp_side(frame_rows_reg);
                    if (col + 1 >= w) begin
                        col = 0;
                        row = (row + 1 >= h) ? 0 : row + 1;
                    end else begin
                        col = col + 1;
                    end
                    col &= 32'hFFF;
                    row &= 32'hFFF;
                end
                FUNC_READ: begin
                    want = '0;
                    if (lab != 0 && lab < LABELS && label_seen[lab] && area_acc[lab] != 0) begin
                        want.present    = 1'b1;
                        want.area       = C_CNT_W'(area_acc[lab]);
                        want.centroid_x = rounded_mean(x_total[lab], area_acc[lab]);
                        want.centroid_y = rounded_mean(y_total[lab], area_acc[lab]);
                        want.box_left   = C_POS_W'(x_lo[lab]);
                        want.box_top    = C_POS_W'(y_lo[lab]);
                        want.box_width  = C_SIDE_W'(x_hi[lab] - x_lo[lab] + 1);
                        want.box_height = C_SIDE_W'(y_hi[lab] - y_lo[lab] + 1);
                    end
                    expected_features.push_back(want);
                end
                FUNC_CLEAR: begin
                    foreach (label_seen[i])
                        label_seen[i] = 1'b0;
                    col = 0;
                    row = 0;
                end
                default: begin
                end
            endcase
        endfunction

        task report(string msg);
            err_count++;
            if (err_count <= PRINT_LIMIT)
                $display("[%0t] MISMATCH %s", $time, msg);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        // Compare one accepted result with the oldest outstanding read.
        task check_result(t_blob_features got);
            t_blob_features want;
            if (expected_features.size() == 0) begin
                report("result arrived with no read request outstanding");
                return;
            end
            want = expected_features.pop_front();
            compare_field("present", 64'(got.present), 64'(want.present));
            compare_field("area", 64'(got.area), 64'(want.area));
            compare_field("centroid_x", 64'(got.centroid_x), 64'(want.centroid_x));
            compare_field("centroid_y", 64'(got.centroid_y), 64'(want.centroid_y));
            compare_field("box_left", 64'(got.box_left), 64'(want.box_left));
            compare_field("box_top", 64'(got.box_top), 64'(want.box_top));
            compare_field("box_width", 64'(got.box_width), 64'(want.box_width));
            compare_field("box_height", 64'(got.box_height), 64'(want.box_height));
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [C_CFG_IDX_W-1:0]  i_cfg_index;
    logic [C_CFG_DATA_W-1:0] i_cfg_wdata;
    logic                    i_valid;
    logic                    o_stall;
    logic [C_FUNC_W-1:0]     i_func;
    logic [C_LABEL_W-1:0]    i_label;
    logic                    o_valid;
    logic                    i_stall;
    logic                    o_present;
    logic [C_CNT_W-1:0]      o_area;
    logic [C_POS_W-1:0]      o_centroid_x;
    logic [C_POS_W-1:0]      o_centroid_y;
    logic [C_POS_W-1:0]      o_box_left;
    logic [C_POS_W-1:0]      o_box_top;
    logic [C_SIDE_W-1:0]     o_box_width;
    logic [C_SIDE_W-1:0]     o_box_height;

    blob_feature_scoreboard sb;
    int                     sender_idle_pct;
    int                     receiver_idle_pct;
    int                     hold_off_request;
    logic [C_LABEL_W-1:0]   label_pool[4];

    blob_feature_accumulator #(
        .LABEL_COUNT(LABELS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_label      (i_label),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_present    (o_present),
        .o_area       (o_area),
        .o_centroid_x (o_centroid_x),
        .o_centroid_y (o_centroid_y),
        .o_box_left   (o_box_left),
        .o_box_top    (o_box_top),
        .o_box_width  (o_box_width),
        .o_box_height (o_box_height)
    );

    // 100 MHz clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Idle gaps: most are short, a few are long.
    function automatic int pick_gap(int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Labels mostly come from the phase pool so that reads find live entries.
    function automatic logic [C_LABEL_W-1:0] pick_label();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75)
            return label_pool[2'($urandom_range(3))];
        if (r < 85)
            return '0;
        return C_LABEL_W'($urandom_range(255));
    endfunction

    // Image sides: mostly small, sometimes large or outside the legal range.
    function automatic logic [C_SIDE_W-1:0] pick_side();
        case ($urandom_range(9))
            0, 1, 2, 3: return C_SIDE_W'($urandom_range(1, 8));
            4, 5:       return C_SIDE_W'($urandom_range(9, 64));
            6:          return 13'd640;
            7:          return C_MAX_SIDE;
            8:          return ($urandom_range(1) != 0) ? 13'd0 : 13'd8191;
            default:    return C_SIDE_W'($urandom_range(8191));
        endcase
    endfunction

    // Offer one request after a random gap and hold it until it is taken.
    task automatic send_request(input logic [C_FUNC_W-1:0] func,
                                input logic [C_LABEL_W-1:0] label);
        int gap;
        gap = pick_gap(sender_idle_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= func;
        i_label <= label;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_request(func, label);
    endtask

    // Stop offering and wait until every read has answered and the block is quiet.
    task automatic drain_results();
        @(negedge i_clk) i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(input t_cfg_idx idx, input logic [C_CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.apply_register(idx, data);
        @(negedge i_clk) i_cfg_we <= 1'b0;
    endtask

    // Program a size, clear, stream pixels of a fresh pool and read every pool label.
    task automatic sweep_frame(input logic [C_SIDE_W-1:0] w, input logic [C_SIDE_W-1:0] h,
                               input int pixels);
        drain_results();
        set_register(CFG_WIDTH, w);
        set_register(CFG_HEIGHT, h);
        label_pool = '{8'd1, 8'd255, C_LABEL_W'($urandom_range(2, 254)),
                       C_LABEL_W'($urandom_range(2, 254))};
        sender_idle_pct = 0;
        send_request(FUNC_CLEAR, '0);
        repeat (pixels) send_request(FUNC_PIXEL, pick_label());
        foreach (label_pool[k])
            send_request(FUNC_READ, label_pool[k]);
        send_request(FUNC_READ, '0);
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        i_stall    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request > 0) begin
                hold_left        = hold_off_request;
                hold_off_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_gap(receiver_idle_pct);
                i_stall <= (stall_left != 0);
                if (stall_left != 0)
                    stall_left--;
            end
        end
    end

    // Check every result taken on a rising edge.
    initial begin : result_monitor
        t_blob_features got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
                got = '{o_present, o_area, o_centroid_x, o_centroid_y,
                        o_box_left, o_box_top, o_box_width, o_box_height};
                sb.check_result(got);
            end
        end
    end

    // Hard stop if the run hangs.
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[%0t] timeout with %0d reads outstanding", $time, sb.pending());
        $display("blob_feature_accumulator verification failed");
        $finish;
    end

    initial begin : stimulus
        int unsigned pick;
        sb                = new();
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_WIDTH;
        i_cfg_wdata       = '0;
        i_valid           = 1'b0;
        i_func            = FUNC_PIXEL;
        i_label           = '0;
        sender_idle_pct   = 30;
        receiver_idle_pct = 30;
        hold_off_request  = 0;
        label_pool        = '{8'd1, 8'd7, 8'd128, 8'd255};
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: absent labels, background, unused code, clear, single-pixel box.
        send_request(FUNC_READ, 8'd9);
        send_request(FUNC_READ, 8'd0);
        send_request(FUNC_PIXEL, 8'd0);
        send_request(FUNC_PIXEL, 8'd255);
        send_request(FUNC_PIXEL, 8'd1);
        send_request(FUNC_PIXEL, 8'd1);
        send_request(FUNC_UNUSED, 8'd200);
        send_request(FUNC_PIXEL, 8'd255);
        send_request(FUNC_READ, 8'd1);
        send_request(FUNC_READ, 8'd255);
        send_request(FUNC_READ, 8'd128);
        send_request(FUNC_CLEAR, 8'd1);
        send_request(FUNC_READ, 8'd1);
        send_request(FUNC_PIXEL, 8'd7);
        send_request(FUNC_READ, 8'd7);
        send_request(FUNC_PIXEL, 8'd0);
        send_request(FUNC_PIXEL, 8'd7);
        send_request(FUNC_READ, 8'd7);
        send_request(FUNC_UNUSED, 8'd255);

        // Extreme sizes: oversized width with zero height, then the reverse,
        // then the exact largest frame.
        sweep_frame(13'd8191, 13'd0, 24);
        sweep_frame(13'd0, 13'd8191, 24);
        sweep_frame(C_MAX_SIDE, C_MAX_SIDE, 24);

        // Random phases. The first one shrinks the width under the current
        // column without clearing, so the position must wrap at the next pixel.
        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            set_register(CFG_WIDTH, (ph == 0) ? C_SIDE_W'($urandom_range(1, 8)) : pick_side());
            set_register(CFG_HEIGHT, pick_side());
            foreach (label_pool[k])
                label_pool[k] = C_LABEL_W'($urandom_range(1, 255));
            sender_idle_pct   = (ph == 1) ? 0 : $urandom_range(10, 50);
            receiver_idle_pct = (ph == 1) ? 0 : $urandom_range(10, 50);
            // Long result hold-off while requests keep coming, to back the block up.
            if (ph == 3)
                hold_off_request = 300;
            if (ph != 0 && $urandom_range(1) != 0)
                send_request(FUNC_CLEAR, C_LABEL_W'($urandom_range(255)));
            for (int n = 0; n < 60; n++) begin
                // Sender pauses until every read has answered.
                if (ph == 5 && n == 40)
                    drain_results();
                pick = $urandom_range(99);
                if (pick < 84)
                    send_request(FUNC_PIXEL, pick_label());
                else if (pick < 96)
                    send_request(FUNC_READ, pick_label());
                else if (pick < 98)
                    send_request(FUNC_CLEAR, C_LABEL_W'($urandom_range(255)));
                else
                    send_request(FUNC_UNUSED, C_LABEL_W'($urandom_range(255)));
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (sb.err_count == 0)
            $display("blob_feature_accumulator verification clean");
        else
            $display("blob_feature_accumulator verification failed");
        $finish;
    end

endmodule

// File: filelist.f
design/bfa_pkg.sv
design/blob_feature_accumulator.sv
bench/blob_feature_accumulator_tb.sv
